/* hw/rtl/lmm_pkg.sv */
package lmm_pkg;

  // statistic word width
  localparam int DataW = 32;
  localparam int OpW   = 3;
  localparam int IdxW  = 4;

  // stream payload widths, padded to whole bytes
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 40;

  // operation codes
  localparam logic [OpW-1:0] OpSched   = 3'd0;
  localparam logic [OpW-1:0] OpSwitch  = 3'd1;
  localparam logic [OpW-1:0] OpPreempt = 3'd2;
  localparam logic [OpW-1:0] OpMigrate = 3'd3;
  localparam logic [OpW-1:0] OpQueue   = 3'd4;
  localparam logic [OpW-1:0] OpClrCnt  = 3'd5;
  localparam logic [OpW-1:0] OpRead    = 3'd6;

  // statistic indexes for a read
  localparam logic [IdxW-1:0] IdxSchedCount  = 4'd0;
  localparam logic [IdxW-1:0] IdxSchedMin    = 4'd1;
  localparam logic [IdxW-1:0] IdxSchedMax    = 4'd2;
  localparam logic [IdxW-1:0] IdxSchedMean   = 4'd3;
  localparam logic [IdxW-1:0] IdxSwitchCount = 4'd4;
  localparam logic [IdxW-1:0] IdxSwitchMax   = 4'd5;
  localparam logic [IdxW-1:0] IdxSwitchMean  = 4'd6;
  localparam logic [IdxW-1:0] IdxPreempt     = 4'd7;
  localparam logic [IdxW-1:0] IdxMigrate     = 4'd8;
  localparam logic [IdxW-1:0] IdxQueuePeak   = 4'd9;
  localparam logic [IdxW-1:0] IdxQueueCur    = 4'd10;
  localparam logic [IdxW-1:0] IdxQueueMin    = 4'd11;
  localparam logic [IdxW-1:0] IdxQueueMax    = 4'd12;
  localparam logic [IdxW-1:0] IdxQueueMean   = 4'd13;
  localparam logic [IdxW-1:0] IdxQueueSmp    = 4'd14;

  typedef logic [DataW-1:0] stat_t;

endpackage

/* hw/rtl/latency_min_max_mean_monitor.sv */
// channel | direction | ports                         | payload
// in      | slave     | in_tvalid in_tready in_tdata  | op, sample_value, stat_index
// out     | master    | out_tvalid out_tready out_tdata | read_data, read_error
//
// a sample that moves a mean goes from transfer to out_tvalid through one multiply,
// one add and divider load, 32 radix-2 divider steps, one mean write, one output load
// every other op, and a sample whose count wraps, goes from the transfer straight to the output load
// one item at a time: in_tready is high only while the sequencer is idle
// the result sits in an output register, so a stalled out side holds only
// the next item's result, not the transfer of the next item itself
// rst_n is synchronous, active low; mins reset to all ones, the rest to zero
module latency_min_max_mean_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [2:0] op, [34:3] sample_value, [38:35] stat_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata    // [31:0] read_data, [32] read_error
);

  localparam int W = lmm_pkg::DataW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    M_SCHED,
    M_SWITCH,
    M_QUEUE
  } msel_t;

  state_t state_r;
  msel_t  msel_r;

  // unpacked input fields
  logic [lmm_pkg::OpW-1:0]  in_op;
  logic [W-1:0]             in_sample_value;
  logic [lmm_pkg::IdxW-1:0] in_stat_index;

  assign in_op           = in_tdata[2:0];
  assign in_sample_value = in_tdata[34:3];
  assign in_stat_index   = in_tdata[38:35];

  // statistics
  lmm_pkg::stat_t sched_count_r, sched_min_r, sched_max_r, sched_mean_r;
  lmm_pkg::stat_t switch_count_r, switch_max_r, switch_mean_r;
  lmm_pkg::stat_t preempt_count_r, migrate_count_r;
  lmm_pkg::stat_t queue_peak_r, queue_current_r, queue_min_r, queue_max_r;
  lmm_pkg::stat_t queue_mean_r, queue_samples_r;

  // mean datapath operands
  logic [W-1:0]   mul_a_r;      // old mean
  logic [W-1:0]   mul_b_r;      // old count, i.e. n - 1
  logic [W-1:0]   n_r;          // new count, the divisor
  logic [W-1:0]   x_r;
  logic [2*W-1:0] prod_r;

  // pending result and output register
  logic [W-1:0] res_data_r;
  logic         res_err_r;
  logic         out_tvalid_r;
  logic [W-1:0] out_data_r;
  logic         out_err_r;

  logic         in_xfer;
  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] rd_data;
  logic         out_free;
  logic         mean_go;

  lmm_pkg::stat_t sched_inc, switch_inc, queue_inc;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign div_start = (state_r == S_ADD);
  assign out_free  = !out_tvalid_r || out_tready;

  assign sched_inc  = sched_count_r + 1'b1;
  assign switch_inc = switch_count_r + 1'b1;
  assign queue_inc  = queue_samples_r + 1'b1;

  // a count that wraps to zero leaves the mean alone
  assign mean_go = ((in_op == lmm_pkg::OpSched)  && (sched_inc  != '0)) ||
                   ((in_op == lmm_pkg::OpSwitch) && (switch_inc != '0)) ||
                   ((in_op == lmm_pkg::OpQueue)  && (queue_inc  != '0));

  // statistic select for a read
  always_comb begin
    unique case (in_stat_index)
      lmm_pkg::IdxSchedCount:  rd_data = sched_count_r;
      lmm_pkg::IdxSchedMin:    rd_data = sched_min_r;
      lmm_pkg::IdxSchedMax:    rd_data = sched_max_r;
      lmm_pkg::IdxSchedMean:   rd_data = sched_mean_r;
      lmm_pkg::IdxSwitchCount: rd_data = switch_count_r;
      lmm_pkg::IdxSwitchMax:   rd_data = switch_max_r;
      lmm_pkg::IdxSwitchMean:  rd_data = switch_mean_r;
      lmm_pkg::IdxPreempt:     rd_data = preempt_count_r;
      lmm_pkg::IdxMigrate:     rd_data = migrate_count_r;
      lmm_pkg::IdxQueuePeak:   rd_data = queue_peak_r;
      lmm_pkg::IdxQueueCur:    rd_data = queue_current_r;
      lmm_pkg::IdxQueueMin:    rd_data = queue_min_r;
      lmm_pkg::IdxQueueMax:    rd_data = queue_max_r;
      lmm_pkg::IdxQueueMean:   rd_data = queue_mean_r;
      lmm_pkg::IdxQueueSmp:    rd_data = queue_samples_r;
      default:                 rd_data = '0;
    endcase
  end

  // shared divider: floor((old_mean * (n - 1) + x) / n)
  lmm_div #(
    .W (W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r + {{W{1'b0}}, x_r}),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_tvalid_r    <= 1'b0;
      sched_count_r   <= '0;
      sched_min_r     <= '1;
      sched_max_r     <= '0;
      sched_mean_r    <= '0;
      switch_count_r  <= '0;
      switch_max_r    <= '0;
      switch_mean_r   <= '0;
      preempt_count_r <= '0;
      migrate_count_r <= '0;
      queue_peak_r    <= '0;
      queue_current_r <= '0;
      queue_min_r     <= '1;
      queue_max_r     <= '0;
      queue_mean_r    <= '0;
      queue_samples_r <= '0;
    end else begin
      // a result leaving while the next one loads is replaced, not cleared
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            // counts, extremes and current depth move at the transfer
            res_data_r <= (in_op == lmm_pkg::OpRead) ? rd_data : '0;
            res_err_r  <= (in_op == lmm_pkg::OpRead) &&
                          (in_stat_index > lmm_pkg::IdxQueueSmp);
            x_r        <= in_sample_value;
            state_r    <= mean_go ? S_MUL : S_OUT;
            case (in_op)
              lmm_pkg::OpSched: begin
                sched_count_r <= sched_inc;
                if (in_sample_value < sched_min_r) sched_min_r <= in_sample_value;
                if (in_sample_value > sched_max_r) sched_max_r <= in_sample_value;
                msel_r  <= M_SCHED;
                mul_a_r <= sched_mean_r;
                mul_b_r <= sched_count_r;
                n_r     <= sched_inc;
              end
              lmm_pkg::OpSwitch: begin
                switch_count_r <= switch_inc;
                if (in_sample_value > switch_max_r) switch_max_r <= in_sample_value;
                msel_r  <= M_SWITCH;
                mul_a_r <= switch_mean_r;
                mul_b_r <= switch_count_r;
                n_r     <= switch_inc;
              end
              lmm_pkg::OpPreempt: begin
                preempt_count_r <= preempt_count_r + 1'b1;
              end
              lmm_pkg::OpMigrate: begin
                migrate_count_r <= migrate_count_r + 1'b1;
              end
              lmm_pkg::OpQueue: begin
                queue_current_r <= in_sample_value;
                queue_samples_r <= queue_inc;
                if (in_sample_value < queue_min_r) queue_min_r <= in_sample_value;
                if (in_sample_value > queue_max_r) queue_max_r <= in_sample_value;
                if (in_sample_value > queue_peak_r) queue_peak_r <= in_sample_value;
                msel_r  <= M_QUEUE;
                mul_a_r <= queue_mean_r;
                mul_b_r <= queue_samples_r;
                n_r     <= queue_inc;
              end
              lmm_pkg::OpClrCnt: begin
                sched_count_r   <= '0;
                switch_count_r  <= '0;
                preempt_count_r <= '0;
                migrate_count_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: begin
          prod_r  <= mul_a_r * mul_b_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          // the sum feeds the divider as it loads
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            unique case (msel_r)
              M_SCHED:  sched_mean_r  <= div_quo;
              M_SWITCH: switch_mean_r <= div_quo;
              M_QUEUE:  queue_mean_r  <= div_quo;
              default: begin
              end
            endcase
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= res_data_r;
            out_err_r    <= res_err_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_err_r, out_data_r};

`ifndef SYNTH
  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  // a transfer always leaves idle, so no second item slips in
  a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  // once any sample has lowered the minimum it cannot exceed the maximum
  a_sched_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (sched_min_r != '1) |-> (sched_min_r <= sched_max_r))
    else $error("schedule minimum above maximum");

  // peak and max see the same samples and neither is ever cleared
  a_queue_peak: assert property (@(posedge clk) disable iff (!rst_n)
    queue_max_r <= queue_peak_r)
    else $error("queue maximum above peak");

  // a queue sample lands in the current depth at once
  a_queue_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_op == lmm_pkg::OpQueue)) |=> (queue_current_r == $past(in_sample_value)))
    else $error("queue current depth not taken from sample");
`endif

endmodule

/* hw/rtl/lmm_div.sv */
module lmm_div #(
  parameter int W = lmm_pkg::DataW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2*W-1:0] dividend,   // quotient must fit in W bits
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [W-1:0]   quotient
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    rem_r;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    dsr_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [W:0] shifted;
  logic [W:0] trial;
  logic       ge;

  // one restoring step a cycle
  assign shifted = {rem_r, quo_r[W-1]};
  assign trial   = shifted - {1'b0, dsr_r};
  assign ge      = ~trial[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(W);
        rem_r  <= dividend[2*W-1:W];
        quo_r  <= dividend[W-1:0];
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? trial[W-1:0] : shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
